// ===== rtl/dpd_pkg.sv =====
package dpd_pkg;

	localparam logic [7:0] START_CHAR = 8'h24;
	localparam logic [7:0] CHECK_CHAR = 8'h23;
	localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_END     = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic        packet_ok;
		logic [15:0] payload_length;
		logic [7:0]  computed_checksum;
		logic [7:0]  received_checksum;
	} result_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end
		return v;
	endfunction

endpackage

// ===== rtl/dpd_if.sv =====
interface dpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpd_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        packet_ok;
	logic [15:0] payload_length;
	logic [7:0]  computed_checksum;
	logic [7:0]  received_checksum;

	modport source (output valid, output kind, output data_byte, output packet_ok,
		output payload_length, output computed_checksum, output received_checksum,
		input ready);
	modport sink (input valid, input kind, input data_byte, input packet_ok,
		input payload_length, input computed_checksum, input received_checksum,
		output ready);
endinterface

// ===== rtl/debug_packet_deframer_unit.sv =====
// A word accepted on rx is held in byte_s1; its result moves into result_q, shown on res, once res is free.
// Throughput: one word per cycle while res is not stalled; the running sum and length update as each word advances.
// Words outside a packet (the start character too), the checksum marker and the first checksum digit give no result.
// Reset is asynchronous and active low; it clears the framing state and both valid flags.
// After reset the block is outside a packet and waits for the start character.
module debug_packet_deframer_unit (
	input  logic clk,
	input  logic arst_n,
	dpd_byte_if.sink     rx,
	dpd_result_if.source res
);
	import dpd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        in_packet_q;
	logic [1:0]  digits_q;
	logic [7:0]  chk_q;
	logic [7:0]  sum_q;
	logic [15:0] len_q;

	logic        in_packet_d;
	logic [1:0]  digits_d;
	logic [7:0]  chk_d;
	logic [7:0]  sum_d;
	logic [15:0] len_d;
	logic        hit_d;
	result_t     result_d;
	result_t     result_q;
	logic        res_valid_q;

	logic        out_free;
	logic        advance;
	logic [3:0]  digit;

	assign out_free = !res_valid_q || res.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;
	assign digit    = hex_value(byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		in_packet_d = in_packet_q;
		digits_d    = digits_q;
		chk_d       = chk_q;
		sum_d       = sum_q;
		len_d       = len_q;
		hit_d       = 1'b0;
		result_d    = '0;
		priority if (!in_packet_q) begin
			if (byte_s1 == START_CHAR) begin
				in_packet_d = 1'b1;
				digits_d    = 2'd0;
				chk_d       = 8'd0;
				sum_d       = 8'd0;
				len_d       = 16'd0;
			end
		end else if (byte_s1 == CHECK_CHAR) begin
			chk_d    = 8'd0;
			digits_d = 2'd2;
		end else if (digits_q != 2'd0) begin
			digits_d = digits_q - 2'd1;
			if (digits_d != 2'd0) begin
				chk_d = {digit, 4'd0};
			end else begin
				chk_d                      = chk_q | {4'd0, digit};
				in_packet_d                = 1'b0;
				hit_d                      = 1'b1;
				result_d.kind              = KIND_END;
				result_d.packet_ok         = (chk_d == sum_q);
				result_d.payload_length    = len_q;
				result_d.computed_checksum = sum_q;
				result_d.received_checksum = chk_d;
			end
		end else begin
			len_d                      = (len_q == LENGTH_MAX) ? len_q : len_q + 16'd1;
			sum_d                      = sum_q + byte_s1;
			hit_d                      = 1'b1;
			result_d.kind              = KIND_PAYLOAD;
			result_d.data_byte         = byte_s1;
			result_d.payload_length    = len_d;
			result_d.computed_checksum = sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			digits_q    <= 2'd0;
			chk_q       <= 8'd0;
			sum_q       <= 8'd0;
			len_q       <= 16'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				in_packet_q <= in_packet_d;
				digits_q    <= digits_d;
				chk_q       <= chk_d;
				sum_q       <= sum_d;
				len_q       <= len_d;
			end
			if (advance && hit_d) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit_d) begin
			result_q <= result_d;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.kind              = result_q.kind;
	assign res.data_byte         = result_q.data_byte;
	assign res.packet_ok         = result_q.packet_ok;
	assign res.payload_length    = result_q.payload_length;
	assign res.computed_checksum = result_q.computed_checksum;
	assign res.received_checksum = result_q.received_checksum;

	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q != 2'd3) else $error("checksum digit count out of range");

	a_digits_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q != 2'd0 |-> in_packet_q) else $error("checksum phase outside a packet");

	a_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && result_q.kind == KIND_END |->
		result_q.packet_ok == (result_q.computed_checksum == result_q.received_checksum)
		&& result_q.data_byte == 8'd0) else $error("packet end word inconsistent");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && result_q.kind == KIND_PAYLOAD |->
		!result_q.packet_ok && result_q.received_checksum == 8'd0
		&& result_q.payload_length != 16'd0) else $error("payload word inconsistent");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import dpd_pkg::*;

	logic clk;
	logic arst_n;

	dpd_byte_if   rx_if ();
	dpd_result_if res_if ();

	debug_packet_deframer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	logic [7:0]  tx_bytes[$];
	result_t     expected_results[$];
	int unsigned pushed_count;
	int unsigned error_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_sender;

	// Shadow of the deframer state.
	logic        in_packet;
	logic [1:0]  digits_left;
	logic [7:0]  checksum_seen;
	logic [7:0]  running_sum;
	logic [15:0] length_count;

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return c[3:0];
		end
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			return c[3:0] + 4'd9;
		end
		return 4'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) begin
			return 8'h30 + v;
		end
		return (upper ? 8'h37 : 8'h57) + v;
	endfunction

	task automatic deframe_byte(input logic [7:0] c);
		result_t r;
		r = '0;
		if (!in_packet) begin
			if (c == START_CHAR) begin
				in_packet     = 1'b1;
				digits_left   = 2'd0;
				checksum_seen = 8'd0;
				running_sum   = 8'd0;
				length_count  = 16'd0;
			end
		end else if (c == CHECK_CHAR) begin
			checksum_seen = 8'd0;
			digits_left   = 2'd2;
		end else if (digits_left != 2'd0) begin
			digits_left = digits_left - 2'd1;
			if (digits_left != 2'd0) begin
				checksum_seen = {digit_value(c), 4'h0};
			end else begin
				checksum_seen       = checksum_seen | {4'h0, digit_value(c)};
				in_packet           = 1'b0;
				r.kind              = KIND_END;
				r.packet_ok         = (checksum_seen == running_sum);
				r.payload_length    = length_count;
				r.computed_checksum = running_sum;
				r.received_checksum = checksum_seen;
				expected_results.push_back(r);
			end
		end else begin
			if (length_count != LENGTH_MAX) begin
				length_count = length_count + 16'd1;
			end
			running_sum         = running_sum + c;
			r.kind              = KIND_PAYLOAD;
			r.data_byte         = c;
			r.payload_length    = length_count;
			r.computed_checksum = running_sum;
			expected_results.push_back(r);
		end
	endtask

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : rx_driver
		if (!arst_n) begin
			rx_if.valid   <= 1'b0;
			rx_if.rx_byte <= 8'd0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				deframe_byte(rx_if.rx_byte);
			end
			if (!rx_if.valid || rx_if.ready) begin
				if (tx_bytes.size() != 0 && !hold_sender &&
						$urandom_range(99) >= send_idle_pct) begin
					rx_if.valid   <= 1'b1;
					rx_if.rx_byte <= tx_bytes.pop_front();
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : res_monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.kind              = kind_t'(res_if.kind);
				got.data_byte         = res_if.data_byte;
				got.packet_ok         = res_if.packet_ok;
				got.payload_length    = res_if.payload_length;
				got.computed_checksum = res_if.computed_checksum;
				got.received_checksum = res_if.received_checksum;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, got);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("data_byte", want.data_byte, got.data_byte);
					check_field("packet_ok", want.packet_ok, got.packet_ok);
					check_field("payload_length", want.payload_length, got.payload_length);
					check_field("computed_checksum", want.computed_checksum,
						got.computed_checksum);
					check_field("received_checksum", want.received_checksum,
						got.received_checksum);
				end
			end
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send(input logic [7:0] b);
		tx_bytes.push_back(b);
		pushed_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send(s[i]);
		end
	endtask

	task automatic send_packet(input int len, input bit good, input bit restart);
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] chk;
		sum = 8'd0;
		send(START_CHAR);
		for (int i = 0; i < len; i++) begin
			do begin
				b = 8'($urandom_range(255));
			end while (b == CHECK_CHAR);
			send(b);
			sum = sum + b;
		end
		send(CHECK_CHAR);
		if (restart) begin
			send(8'($urandom_range(255)));
			send(CHECK_CHAR);
		end
		chk = good ? sum : 8'($urandom_range(255));
		send(hex_char(chk[7:4], 1'($urandom_range(1))));
		send(hex_char(chk[3:0], 1'($urandom_range(1))));
	endtask

	task automatic wait_drained();
		while (tx_bytes.size() != 0 || rx_if.valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic send_random(input int unsigned count);
		int unsigned pick;
		int unsigned len;
		pushed_count = 0;
		while (pushed_count < count) begin
			pick = $urandom_range(99);
			len  = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(12);
			if (pick < 72) begin
				send_packet(len, $urandom_range(99) < 60, 1'b0);
			end else if (pick < 80) begin
				send_packet(len, 1'b1, 1'b1);
			end else if (pick < 90) begin
				send(8'($urandom_range(255)));
			end else begin
				send(START_CHAR);
				repeat (len) send(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[debug_packet_deframer_unit] ERROR");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.rx_byte  = 8'd0;
		res_if.ready   = 1'b0;
		hold_sender    = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		pushed_count   = 0;
		in_packet      = 1'b0;
		digits_left    = 2'd0;
		checksum_seen  = 8'd0;
		running_sum    = 8'd0;
		length_count   = 16'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Noise outside a packet, then packets covering the checksum corner cases.
		send_text("A#");
		send(8'hFF);
		send(8'h00);
		send(START_CHAR);
		send(8'h00);
		send(8'hFF);
		send(START_CHAR);
		send(8'h80);
		send_text("#7#a3");
		send_text("$0#z$");
		send_text("$#00");
		send_text("$#Ff");
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 86 : 25) : 0;
			recv_stall_pct = (phase == 2) ? 86 : ((phase == 3) ? 25 : 0);
			send_random(460);
			if (phase == 0) begin
				while (tx_bytes.size() > 200) begin
					@(negedge clk);
				end
				hold_sender = 1'b1;
				while (rx_if.valid || expected_results.size() != 0) begin
					@(negedge clk);
				end
				repeat (3) @(negedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("[debug_packet_deframer_unit] OK");
		end else begin
			$display("[debug_packet_deframer_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dpd_pkg.sv
rtl/dpd_if.sv
rtl/debug_packet_deframer_unit.sv
test/tb_top.sv
